// ===== rtl/cpot_pkg.sv =====
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared types and constants of the convex polygon overlap test.
// ----------------------------------------------------------------------------
package cpot_pkg;

  // Default configuration of the block.
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // A polygon needs at least this many vertices to be tested.
  localparam int MIN_VERTICES = 3;

  // Polygon codes carried by polygon_select.
  localparam logic POLY_FIRST  = 1'b0;
  localparam logic POLY_SECOND = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_C,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_DONE
  } cpot_state_t;

  // Control that travels with one vertex into a projection lane.
  typedef struct packed {
    logic valid;
    logic first;
  } cpot_lane_ctl_t;

endpackage

// ===== rtl/cpot_if.sv =====
// ----------------------------------------------------------------------------
// cpot_if
// Channel interfaces: vertex input and overlap result.
// ----------------------------------------------------------------------------
interface vertex_if #(
  parameter int COORD_BITS = cpot_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         polygon_select;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, output polygon_select, output vertex_x,
                  output vertex_y, output last_vertex, input ready);
  modport sink   (input valid, input polygon_select, input vertex_x,
                  input vertex_y, input last_vertex, output ready);
endinterface

interface result_if;
  logic valid;
  logic ready;
  logic overlap;
  logic error;

  modport source (output valid, output overlap, output error, input ready);
  modport sink   (input valid, input overlap, input error, output ready);
endinterface

// ===== rtl/cpot_store.sv =====
// ----------------------------------------------------------------------------
// cpot_store
// Vertex memory of one polygon: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpot_store #(
  parameter int DEPTH      = cpot_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [COORD_BITS-1:0]        wx,
  input  logic [COORD_BITS-1:0]        wy,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic signed [COORD_BITS-1:0] rx,
  output logic signed [COORD_BITS-1:0] ry
);
  import cpot_pkg::*;

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rdata;

  // Write and read ports; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
    rdata <= mem[raddr];
  end

  assign rx = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
  assign ry = $signed(rdata[COORD_BITS-1:0]);

endmodule

// ===== rtl/cpot_lane.sv =====
// ----------------------------------------------------------------------------
// cpot_lane
// Projection lane: projects a vertex stream onto an axis and tracks the
// minimum and maximum projection.
// ----------------------------------------------------------------------------
module cpot_lane #(
  parameter int COORD_BITS = cpot_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cpot_pkg::cpot_lane_ctl_t        ctl,
  input  logic signed [COORD_BITS:0]      ax,
  input  logic signed [COORD_BITS:0]      ay,
  input  logic signed [COORD_BITS-1:0]    x,
  input  logic signed [COORD_BITS-1:0]    y,
  output logic                            busy,
  output logic signed [2*COORD_BITS+1:0]  lo,
  output logic signed [2*COORD_BITS+1:0]  hi
);
  import cpot_pkg::*;

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int MW = 2 * COORD_BITS + 1;

  logic                          v2;
  logic                          f2;
  logic signed [2*COORD_BITS:0]  px;
  logic signed [2*COORD_BITS:0]  py;
  logic                          v3;
  logic                          f3;
  logic signed [PW-1:0]          dot;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= ctl.valid;
      v3 <= v2;
    end
  end

  // Products, then their sum.
  always_ff @(posedge clk) begin
    f2  <= ctl.first;
    px  <= MW'(ax) * MW'(x);
    py  <= MW'(ay) * MW'(y);
    f3  <= f2;
    dot <= PW'(px) + PW'(py);
  end

  // Interval update; the first vertex of a pass restarts the interval.
  always_ff @(posedge clk) begin
    if (v3) begin
      if (f3) begin
        lo <= dot;
        hi <= dot;
      end else begin
        if (dot < lo) begin
          lo <= dot;
        end
        if (dot > hi) begin
          hi <= dot;
        end
      end
    end
  end

  assign busy = v2 | v3;

endmodule

// ===== rtl/convex_polygon_overlap_test_top.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_overlap_test_top
// Separating axis overlap test of two convex polygons loaded vertex by vertex.
// ----------------------------------------------------------------------------
// Loading: one vertex per cycle while the sequencer is idle, as ready is low during a
// test; a vertex that ends no pair gives no result. Test: after the second polygon's
// last vertex, (n1 + n2) axes are walked, each through the edge fetch states, the
// vertex memory scan and a drain of the projection pipeline; an axis that separates ends the test early.
// An error result skips the axis walk and goes straight to the result register.
// Reset clears the counts, the overflow flag, the sequencer, the lane feed controls,
// the lane valid bits and the result valid flag only.
module convex_polygon_overlap_test_top #(
  parameter int MAX_VERTICES = cpot_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = cpot_pkg::COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  vertex_if.sink   vin,
  result_if.source res
);
  import cpot_pkg::*;

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_VERTICES);
  localparam logic [CNTW-1:0] MINC = CNTW'(MIN_VERTICES);

  cpot_state_t state, state_next;

  // Load bookkeeping.
  logic [CNTW-1:0] cnt1;
  logic [CNTW-1:0] cnt2;
  logic            ovf;

  // Test registers.
  logic [CNTW-1:0]              n1;
  logic [CNTW-1:0]              n2;
  logic                         axis_poly;
  logic [AW-1:0]                edge_idx;
  logic [AW-1:0]                scan_idx;
  logic signed [COORD_BITS-1:0] ex;
  logic signed [COORD_BITS-1:0] ey;
  logic signed [COORD_BITS:0]   ax;
  logic signed [COORD_BITS:0]   ay;
  cpot_lane_ctl_t               ctl_a;
  cpot_lane_ctl_t               ctl_b;
  logic                         res_overlap;
  logic                         res_error;

  // Output register.
  logic out_valid;
  logic out_overlap;
  logic out_error;

  // Combinational control.
  logic                         accept;
  logic                         trigger;
  logic                         full_sel;
  logic                         we1;
  logic                         we2;
  logic [CNTW-1:0]              cnt1_upd;
  logic [CNTW-1:0]              cnt2_upd;
  logic                         ovf_upd;
  logic                         err_upd;
  logic [AW-1:0]                raddr;
  logic signed [COORD_BITS-1:0] rx1;
  logic signed [COORD_BITS-1:0] ry1;
  logic signed [COORD_BITS-1:0] rx2;
  logic signed [COORD_BITS-1:0] ry2;
  logic signed [COORD_BITS-1:0] sel_x;
  logic signed [COORD_BITS-1:0] sel_y;
  logic [CNTW-1:0]              n_axis;
  logic [CNTW-1:0]              edge_inc;
  logic                         last_edge;
  logic [AW-1:0]                edge_nxt;
  logic [CNTW-1:0]              scan_max;
  logic                         scan_end;
  logic                         busy_a;
  logic                         busy_b;
  logic signed [2*COORD_BITS+1:0] lo_a;
  logic signed [2*COORD_BITS+1:0] hi_a;
  logic signed [2*COORD_BITS+1:0] lo_b;
  logic signed [2*COORD_BITS+1:0] hi_b;
  logic                         separated;
  logic                         drained;
  logic                         load_out;

  // Input transaction decode and count update.
  assign accept   = vin.valid & vin.ready;
  assign trigger  = (vin.polygon_select == POLY_SECOND) & vin.last_vertex;
  assign full_sel = (vin.polygon_select == POLY_SECOND) ? (cnt2 >= MAXC)
                                                        : (cnt1 >= MAXC);
  assign we1 = accept & (vin.polygon_select == POLY_FIRST) & ~full_sel;
  assign we2 = accept & (vin.polygon_select == POLY_SECOND) & ~full_sel;
  assign cnt1_upd = we1 ? cnt1 + CNTW'(1) : cnt1;
  assign cnt2_upd = we2 ? cnt2 + CNTW'(1) : cnt2;
  assign ovf_upd  = ovf | full_sel;
  assign err_upd  = ovf_upd | (cnt1_upd < MINC) | (cnt2_upd < MINC);

  // Edge and scan indexing.
  assign n_axis    = (axis_poly == POLY_SECOND) ? n2 : n1;
  assign edge_inc  = CNTW'(edge_idx) + CNTW'(1);
  assign last_edge = (edge_inc == n_axis);
  assign edge_nxt  = last_edge ? '0 : edge_inc[AW-1:0];
  assign scan_max  = (n1 > n2) ? n1 : n2;
  assign scan_end  = (CNTW'(scan_idx) + CNTW'(1)) == scan_max;
  assign sel_x     = (axis_poly == POLY_SECOND) ? rx2 : rx1;
  assign sel_y     = (axis_poly == POLY_SECOND) ? ry2 : ry1;
  assign drained   = ~ctl_a.valid & ~ctl_b.valid & ~busy_a & ~busy_b;
  assign separated = (hi_a < lo_b) | (hi_b < lo_a);

  // Vertex memories.
  cpot_store #(.DEPTH(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_store1 (
    .clk   (clk),
    .we    (we1),
    .waddr (cnt1[AW-1:0]),
    .wx    (vin.vertex_x),
    .wy    (vin.vertex_y),
    .raddr (raddr),
    .rx    (rx1),
    .ry    (ry1)
  );

  cpot_store #(.DEPTH(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_store2 (
    .clk   (clk),
    .we    (we2),
    .waddr (cnt2[AW-1:0]),
    .wx    (vin.vertex_x),
    .wy    (vin.vertex_y),
    .raddr (raddr),
    .rx    (rx2),
    .ry    (ry2)
  );

  // Projection lanes, one for each polygon.
  cpot_lane #(.COORD_BITS(COORD_BITS)) u_lane_a (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_a),
    .ax   (ax),
    .ay   (ay),
    .x    (rx1),
    .y    (ry1),
    .busy (busy_a),
    .lo   (lo_a),
    .hi   (hi_a)
  );

  cpot_lane #(.COORD_BITS(COORD_BITS)) u_lane_b (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_b),
    .ax   (ax),
    .ay   (ay),
    .x    (rx2),
    .y    (ry2),
    .busy (busy_b),
    .lo   (lo_b),
    .hi   (hi_b)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && trigger) begin
          state_next = err_upd ? S_DONE : S_EDGE_A;
        end
      end
      S_EDGE_A: state_next = S_EDGE_B;
      S_EDGE_B: state_next = S_EDGE_C;
      S_EDGE_C: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (separated || (last_edge && axis_poly == POLY_SECOND)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_EDGE_A;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    vin.ready = 1'b0;
    raddr     = scan_idx;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE:   vin.ready = 1'b1;
      S_EDGE_A: raddr = edge_idx;
      S_EDGE_B: raddr = edge_nxt;
      S_DONE:   load_out = ~out_valid | res.ready;
      default:  raddr = scan_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Vertex counts and overflow flag; a closing vertex hands them to the test.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt1 <= '0;
      cnt2 <= '0;
      ovf  <= 1'b0;
    end else if (accept) begin
      if (trigger) begin
        cnt1 <= '0;
        cnt2 <= '0;
        ovf  <= 1'b0;
      end else begin
        cnt1 <= cnt1_upd;
        cnt2 <= cnt2_upd;
        ovf  <= ovf_upd;
      end
    end
  end

  // Lane feed valid and first-vertex bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
    end else begin
      ctl_a.valid <= (state == S_SCAN) && (CNTW'(scan_idx) < n1);
      ctl_b.valid <= (state == S_SCAN) && (CNTW'(scan_idx) < n2);
      ctl_a.first <= (scan_idx == '0);
      ctl_b.first <= (scan_idx == '0);
    end
  end

  // Test sequencing datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && trigger) begin
          n1          <= cnt1_upd;
          n2          <= cnt2_upd;
          axis_poly   <= POLY_FIRST;
          edge_idx    <= '0;
          res_overlap <= 1'b0;
          res_error   <= err_upd;
        end
      end
      S_EDGE_B: begin
        ex <= sel_x;
        ey <= sel_y;
      end
      S_EDGE_C: begin
        // Edge normal (-dy, dx).
        ax       <= (COORD_BITS+1)'(ey) - (COORD_BITS+1)'(sel_y);
        ay       <= (COORD_BITS+1)'(sel_x) - (COORD_BITS+1)'(ex);
        scan_idx <= '0;
      end
      S_SCAN: begin
        scan_idx <= scan_idx + AW'(1);
      end
      S_CHECK: begin
        if (separated) begin
          res_overlap <= 1'b0;
        end else if (last_edge) begin
          if (axis_poly == POLY_SECOND) begin
            res_overlap <= 1'b1;
          end else begin
            axis_poly <= POLY_SECOND;
            edge_idx  <= '0;
          end
        end else begin
          edge_idx <= edge_inc[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register; a waiting transaction holds until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_overlap <= res_overlap;
      out_error   <= res_error;
    end
  end

  assign res.valid   = out_valid;
  assign res.overlap = out_overlap;
  assign res.error   = out_error;

endmodule

// ===== tb/sv/tb_convex_polygon_overlap_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_overlap_test_top
// Self-checking testbench of the separating axis polygon overlap test.
// Vertex pairs are loaded through the vertex channel while a scoreboard
// predicts each verdict with exact integer projections on every edge normal.
// Directed pairs cover the coordinate extremes, touching polygons, a repeated
// vertex, a vertex after the first polygon's last flag and a short polygon.
// Random pairs add convex rings, noise points, store overflow and interleaved
// loads, with random idling on both channels and a long result back-pressure.
// ----------------------------------------------------------------------------
module tb_convex_polygon_overlap_test_top;
  import cpot_pkg::*;

  localparam int MAX_V         = MAX_VERTICES_DEF;
  localparam int COORD_W       = COORD_BITS_DEF;
  localparam int IDLE_PCT      = 7;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 540;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PAUSE_PAIR    = 36;
  // Directions at 22.5 degree steps, scaled by 1000.
  localparam int RING_COS[16] = '{1000, 924, 707, 383, 0, -383, -707, -924,
                                  -1000, -924, -707, -383, 0, 383, 707, 924};

  typedef struct {
    longint x;
    longint y;
  } corner_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt16_t;

  typedef struct packed {
    logic                      sel;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } vertex_item_t;

  typedef struct packed {
    logic overlap;
    logic error;
  } verdict_t;

  // Predicts one verdict per closed polygon pair and checks the results.
  class overlap_checker;
    corner_t     corners[2][MAX_V];
    int unsigned counts[2];
    bit          overflowed;
    verdict_t    verdicts_due[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned overlaps;
    int unsigned gaps;
    int unsigned error_verdicts;

    function new();
      counts[0]      = 0;
      counts[1]      = 0;
      overflowed     = 1'b0;
      failures       = 0;
      checked        = 0;
      overlaps       = 0;
      gaps           = 0;
      error_verdicts = 0;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    // Min and max projection of one polygon onto the axis (ax, ay).
    function void span(int side, longint ax, longint ay,
                       output longint lo, output longint hi);
      longint d;
      lo = ax * corners[side][0].x + ay * corners[side][0].y;
      hi = lo;
      for (int i = 1; i < counts[side]; i++) begin
        d = ax * corners[side][i].x + ay * corners[side][i].y;
        if (d < lo) lo = d;
        if (d > hi) hi = d;
      end
    endfunction

    // True if some edge normal of the given polygon splits the two polygons.
    function bit edge_gap(int side);
      int     n;
      int     nx;
      longint dx;
      longint dy;
      longint lo_a;
      longint hi_a;
      longint lo_b;
      longint hi_b;
      n = counts[side];
      for (int e = 0; e < n; e++) begin
        nx = (e + 1 == n) ? 0 : e + 1;
        dx = corners[side][nx].x - corners[side][e].x;
        dy = corners[side][nx].y - corners[side][e].y;
        span(0, -dy, dx, lo_a, hi_a);
        span(1, -dy, dx, lo_b, hi_b);
        if (hi_a < lo_b || hi_b < lo_a) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Stores an accepted vertex; a closing vertex yields one verdict.
    function void absorb_vertex(logic sel, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y, logic last);
      int       s;
      verdict_t v;
      s = (sel == POLY_SECOND) ? 1 : 0;
      if (counts[s] < MAX_V) begin
        corners[s][counts[s]].x = longint'(x);
        corners[s][counts[s]].y = longint'(y);
        counts[s]++;
      end else begin
        overflowed = 1'b1;
      end
      if (!(sel == POLY_SECOND && last)) return;
      v.error   = overflowed || counts[0] < MIN_VERTICES || counts[1] < MIN_VERTICES;
      v.overlap = 1'b0;
      if (!v.error) v.overlap = !edge_gap(0) && !edge_gap(1);
      verdicts_due.push_back(v);
      counts[0]  = 0;
      counts[1]  = 0;
      overflowed = 1'b0;
    endfunction

    // Compares one result transaction with the oldest verdict due.
    function void check_result(logic overlap, logic error);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual overlap=%0b error=%0b",
                 $time, overlap, error);
        failures++;
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (want.error) error_verdicts++;
      else if (want.overlap) overlaps++;
      else gaps++;
      if (overlap !== want.overlap) begin
        $display("%0t: overlap mismatch: expected %0b, actual %0b",
                 $time, want.overlap, overlap);
        failures++;
      end
      if (error !== want.error) begin
        $display("%0t: error mismatch: expected %0b, actual %0b",
                 $time, want.error, error);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  vertex_if #(.COORD_BITS(COORD_W)) vin_ch();
  result_if                         res_ch();

  convex_polygon_overlap_test_top #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .vin(vin_ch),
    .res(res_ch)
  );

  overlap_checker sb;
  pt16_t          shape_q[2][$];
  int unsigned    vertices_sent;
  int unsigned    pairs_sent;
  int unsigned    cycle_count;
  bit             sender_calm;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter with a hard limit on the run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts still due",
               cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic void push_pt(input int side, input int x, input int y);
    pt16_t p;
    p.x = clamp16(x);
    p.y = clamp16(y);
    shape_q[side].push_back(p);
  endfunction

  // Convex ring: n distinct directions around a random center, either winding.
  function automatic void fill_ring(input int side, input int n, input bit big);
    bit    chosen[16];
    int    got;
    int    k;
    int    spread;
    int    cx;
    int    cy;
    int    r;
    bit    ccw;
    pt16_t p;
    chosen = '{default: 1'b0};
    got    = 0;
    while (got < n) begin
      k = $urandom_range(0, 15);
      if (!chosen[k]) begin
        chosen[k] = 1'b1;
        got++;
      end
    end
    spread = big ? 16000 : 3000;
    cx     = int'($urandom_range(0, 2 * spread)) - spread;
    cy     = int'($urandom_range(0, 2 * spread)) - spread;
    r      = big ? int'($urandom_range(2000, 16000)) : int'($urandom_range(20, 2000));
    ccw    = $urandom_range(0, 1);
    for (k = 0; k < 16; k++) begin
      if (chosen[k]) begin
        p.x = clamp16(cx + r * RING_COS[k] / 1000);
        p.y = clamp16(cy + r * RING_COS[(k + 12) % 16] / 1000);
        if (ccw) shape_q[side].push_back(p);
        else shape_q[side].push_front(p);
        // Now and then repeat a vertex to get a zero-length edge.
        if (n < MAX_V && $urandom_range(0, 24) == 0) shape_q[side].push_back(p);
      end
    end
  endfunction

  // Points anywhere in the coordinate range.
  function automatic void fill_noise(input int side, input int n);
    pt16_t p;
    for (int i = 0; i < n; i++) begin
      p.x = COORD_W'($urandom_range(0, 65535));
      p.y = COORD_W'($urandom_range(0, 65535));
      shape_q[side].push_back(p);
    end
  endfunction

  // Offers one vertex transaction, with random idle cycles in front of it.
  task automatic send_vertex(input vertex_item_t it);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      vin_ch.valid <= 1'b0;
      @(negedge clk);
    end
    vin_ch.valid          <= 1'b1;
    vin_ch.polygon_select <= it.sel;
    vin_ch.vertex_x       <= it.x;
    vin_ch.vertex_y       <= it.y;
    vin_ch.last_vertex    <= it.last;
    do @(posedge clk); while (!vin_ch.ready);
    sb.absorb_vertex(it.sel, it.x, it.y, it.last);
    vertices_sent++;
    @(negedge clk);
  endtask

  // Loads the queued pair; the second polygon's last vertex always closes it.
  task automatic send_shapes(input int first_last_pos, input bit mix);
    int           a;
    int           b;
    int           n1;
    int           n2;
    bit           take_first;
    vertex_item_t it;
    n1 = shape_q[0].size();
    n2 = shape_q[1].size();
    a  = 0;
    b  = 0;
    while (a < n1 || b < n2 - 1) begin
      take_first = (a < n1) && (!mix || b >= n2 - 1 || $urandom_range(0, 1) == 1);
      if (take_first) begin
        it.sel  = POLY_FIRST;
        it.x    = shape_q[0][a].x;
        it.y    = shape_q[0][a].y;
        it.last = (a == first_last_pos);
        a++;
      end else begin
        it.sel  = POLY_SECOND;
        it.x    = shape_q[1][b].x;
        it.y    = shape_q[1][b].y;
        it.last = 1'b0;
        b++;
      end
      send_vertex(it);
    end
    it.sel  = POLY_SECOND;
    it.x    = shape_q[1][n2-1].x;
    it.y    = shape_q[1][n2-1].y;
    it.last = 1'b1;
    send_vertex(it);
    shape_q[0].delete();
    shape_q[1].delete();
    pairs_sent++;
  endtask

  // Result side: random idling, one long hold-off and one stretch always ready.
  initial begin
    int unsigned hold_left;
    bit          held;
    res_ch.ready = 1'b0;
    hold_left    = 0;
    held         = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && sb.checked == 10) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (sb.checked >= 40 && sb.checked < 55) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.overlap, res_ch.error);
      @(negedge clk);
    end
  end

  // Stimulus: directed pairs, then random pairs.
  initial begin
    int kind;
    int side;
    int n1;
    int last_pos;
    bit big;
    sb                    = new();
    vertices_sent         = 0;
    pairs_sent            = 0;
    sender_calm           = 1'b0;
    rst                   = 1'b1;
    vin_ch.valid          = 1'b0;
    vin_ch.polygon_select = POLY_FIRST;
    vin_ch.vertex_x       = '0;
    vin_ch.vertex_y       = '0;
    vin_ch.last_vertex    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Coordinate extremes: a small triangle inside a full-range one, interleaved.
    push_pt(0, -32768, -32768);
    push_pt(0, 32767, -32768);
    push_pt(0, 32767, 32767);
    push_pt(1, 100, -100);
    push_pt(1, 200, -100);
    push_pt(1, 200, 0);
    send_shapes(2, 1'b1);

    // Repeated vertex in the first polygon, far-apart triangles.
    push_pt(0, 0, 0);
    push_pt(0, 0, 0);
    push_pt(0, 10, 0);
    push_pt(0, 0, 10);
    push_pt(1, 100, 100);
    push_pt(1, 110, 100);
    push_pt(1, 100, 110);
    send_shapes(3, 1'b0);

    // Triangles touching at one point; the first's last flag comes early.
    push_pt(0, 0, 0);
    push_pt(0, 10, 0);
    push_pt(0, 0, 10);
    push_pt(1, 10, 0);
    push_pt(1, 20, 0);
    push_pt(1, 10, 10);
    send_shapes(1, 1'b0);

    // First polygon too short to test.
    push_pt(0, 5, 5);
    push_pt(0, 6, 6);
    push_pt(1, 0, 0);
    push_pt(1, 1, 0);
    push_pt(1, 0, 1);
    send_shapes(1, 1'b0);

    // Random pairs: mostly convex rings, some noise, overflow and short polygons.
    while (vertices_sent < ITEM_TARGET) begin
      sender_calm = (pairs_sent >= 20 && pairs_sent < 32);
      if (pairs_sent == PAUSE_PAIR) begin
        vin_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 99);
      big  = ($urandom_range(0, 9) < 3);
      if (kind < 78) begin
        for (int s = 0; s < 2; s++) begin
          fill_ring(s, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(3, 6), big);
        end
      end else if (kind < 88) begin
        fill_noise(0, $urandom_range(3, 5));
        fill_noise(1, $urandom_range(3, 5));
      end else if (kind < 94) begin
        side = $urandom_range(0, 1);
        fill_noise(side, $urandom_range(MAX_V + 1, MAX_V + 3));
        fill_ring(1 - side, $urandom_range(3, 5), big);
      end else begin
        side = $urandom_range(0, 1);
        fill_noise(side, (side == 1) ? $urandom_range(1, MIN_VERTICES - 1)
                                     : $urandom_range(0, MIN_VERTICES - 1));
        fill_ring(1 - side, $urandom_range(3, 5), big);
      end
      n1       = shape_q[0].size();
      last_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n1) : n1 - 1;
      send_shapes(last_pos, $urandom_range(0, 4) == 0);
    end
    vin_ch.valid <= 1'b0;

    // Drain the remaining verdicts, then watch for stray results.
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Loaded %0d vertex transactions in %0d polygon pairs in %0d cycles.",
             vertices_sent, pairs_sent, cycle_count);
    $display("Checked %0d verdicts: %0d overlap, %0d separated, %0d error; %0d mismatches.",
             sb.checked, sb.overlaps, sb.gaps, sb.error_verdicts, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== convex_polygon_overlap_test_top.f =====
rtl/cpot_pkg.sv
rtl/cpot_if.sv
rtl/cpot_store.sv
rtl/cpot_lane.sv
rtl/convex_polygon_overlap_test_top.sv
tb/sv/tb_convex_polygon_overlap_test_top.sv
